>>> design/oaf_pkg.sv
package oaf_pkg;

	// default memory depth in words
	localparam int unsigned MEM_WORDS_DEF = 32768;

	// request codes
	typedef enum logic [1:0] {
		REQ_WR_REG = 2'd0,
		REQ_WR_MEM = 2'd1,
		REQ_FETCH  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	// addressing modes
	localparam logic [2:0] MODE_REG     = 3'd0;
	localparam logic [2:0] MODE_DEF     = 3'd1;
	localparam logic [2:0] MODE_INC     = 3'd2;
	localparam logic [2:0] MODE_INC_DEF = 3'd3;
	localparam logic [2:0] MODE_DEC     = 3'd4;
	localparam logic [2:0] MODE_DEC_DEF = 3'd5;
	localparam logic [2:0] MODE_IDX     = 3'd6;
	localparam logic [2:0] MODE_IDX_DEF = 3'd7;

	// special registers
	localparam logic [2:0] SP_REG = 3'd6;
	localparam logic [2:0] PC_REG = 3'd7;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_OPND,
		ST_IDX,
		ST_IDXADD,
		ST_PTR,
		ST_VAL,
		ST_DONE
	} state_t;

	// memory port request
	typedef struct packed {
		logic        rd;
		logic        wr;
		logic [15:0] addr;
		logic [15:0] wdata;
	} mem_req_t;

	// word index of a byte address lies past the end of memory
	function automatic logic word_oob(input logic [15:0] addr, input logic [15:0] words);
		word_oob = ({1'b0, addr[15:1]} >= words);
	endfunction

	// sign-extend a byte to a word
	function automatic logic [15:0] sext8(input logic [7:0] b);
		sext8 = {{8{b[7]}}, b};
	endfunction

endpackage

>>> design/operand_address_fetch.sv
// channel  dir  handshake             fields
// in       in   in_valid / in_stall   req_type src_mode src_reg dst_mode dst_reg byte_op
//                                     write_target write_data
// out      out  out_valid / out_stall src_value src_address src_step dst_value
//                                     dst_address dst_step pc_step write_ack
//
// one request at a time: in_stall is high from acceptance until the result enters the
// output register. a fetch runs longer than a write, its length set by the modes of
// both operands and by the dependent reads through the single memory read port and
// the one shared adder.
// a result held by out_stall keeps the next one, and in_stall, waiting until it moves.
// reset clears the register file and control; memory needs no clearing pass.
module operand_address_fetch #(
	parameter int unsigned MEM_WORDS = oaf_pkg::MEM_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [2:0]         src_mode,
	input  logic [2:0]         src_reg,
	input  logic [2:0]         dst_mode,
	input  logic [2:0]         dst_reg,
	input  logic               byte_op,
	input  logic [15:0]        write_target,
	input  logic [15:0]        write_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] src_value,
	output logic [15:0]        src_address,
	output logic signed [2:0]  src_step,
	output logic signed [15:0] dst_value,
	output logic [15:0]        dst_address,
	output logic signed [2:0]  dst_step,
	output logic [2:0]         pc_step,
	output logic               write_ack
);

	localparam logic [15:0] MEM_LIMIT = 16'(MEM_WORDS);

	oaf_pkg::state_t   state_q, state_d;
	oaf_pkg::mem_req_t mem_req;
	logic [15:0]       rd_data;

	// latched request
	oaf_pkg::req_t req_q;
	logic [2:0]    src_mode_q, src_reg_q, dst_mode_q, dst_reg_q;
	logic          byte_q;
	logic [15:0]   target_q, data_q;

	// sequencer state
	logic          op_q;
	logic [2:0]    pcs_q;
	logic [15:0]   addr_q, base_q, x_q;
	logic [15:0]   regs_q [8];

	// result under construction
	logic [15:0]   res_src_value_q, res_src_address_q, res_dst_value_q, res_dst_address_q;
	logic [2:0]    res_src_step_q, res_dst_step_q, res_pc_step_q;
	logic          res_ack_q;

	// output register
	logic          out_valid_q;
	logic [15:0]   src_value_q, src_address_q, dst_value_q, dst_address_q;
	logic [2:0]    src_step_q, dst_step_q, pc_step_q;
	logic          write_ack_q;

	logic          in_accept, reg_we, opnd_done, load_out, start_ack;
	logic [2:0]    cur_mode, cur_reg, step_d, opnd_step;
	logic [15:0]   r_val, pc_val, add_a, add_b, add_sum, opnd_val, opnd_addr;
	logic [7:0]    val_byte;

	oaf_mem #(
		.MEM_WORDS(MEM_WORDS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rd_data(rd_data)
	);

	assign in_stall  = (state_q != oaf_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// current operand
	assign cur_mode = op_q ? dst_mode_q : src_mode_q;
	assign cur_reg  = op_q ? dst_reg_q : src_reg_q;
	assign r_val    = regs_q[cur_reg];
	assign pc_val   = regs_q[oaf_pkg::PC_REG];
	assign step_d   = (byte_q && (cur_reg < oaf_pkg::SP_REG)) ? 3'd1 : 3'd2;

	// shared adder
	assign add_sum = add_a + add_b;

	// register step by mode
	always_comb begin
		case (cur_mode)
			oaf_pkg::MODE_INC:     opnd_step = step_d;
			oaf_pkg::MODE_INC_DEF: opnd_step = 3'd2;
			oaf_pkg::MODE_DEC:     opnd_step = 3'd0 - step_d;
			oaf_pkg::MODE_DEC_DEF: opnd_step = 3'd0 - 3'd2;
			default:               opnd_step = 3'd0;
		endcase
	end

	// operand value and address at completion
	assign val_byte  = addr_q[0] ? rd_data[15:8] : rd_data[7:0];
	assign opnd_addr = (state_q == oaf_pkg::ST_OPND) ? 16'h0000 : addr_q;
	always_comb begin
		if (state_q == oaf_pkg::ST_OPND) begin
			opnd_val = byte_q ? oaf_pkg::sext8(r_val[7:0]) : r_val;
		end else begin
			opnd_val = byte_q ? oaf_pkg::sext8(val_byte) : rd_data;
		end
	end

	assign start_ack = (req_q == oaf_pkg::REQ_WR_REG) ? (target_q[15:3] == 13'd0)
		: (req_q == oaf_pkg::REQ_WR_MEM) ? !oaf_pkg::word_oob(target_q, MEM_LIMIT)
		: 1'b0;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, adder operands and memory requests
	always_comb begin
		state_d   = state_q;
		mem_req   = '0;
		add_a     = r_val;
		add_b     = 16'h0000;
		reg_we    = 1'b0;
		opnd_done = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			oaf_pkg::ST_IDLE: begin
				if (in_valid) state_d = oaf_pkg::ST_START;
			end
			oaf_pkg::ST_START: begin
				mem_req.addr  = target_q;
				mem_req.wdata = data_q;
				case (req_q)
					oaf_pkg::REQ_WR_REG: reg_we = start_ack;
					oaf_pkg::REQ_WR_MEM: mem_req.wr = start_ack;
					default: ;
				endcase
				state_d = (req_q == oaf_pkg::REQ_FETCH) ? oaf_pkg::ST_OPND
					: oaf_pkg::ST_DONE;
			end
			oaf_pkg::ST_OPND: begin
				case (cur_mode)
					oaf_pkg::MODE_REG: opnd_done = 1'b1;
					oaf_pkg::MODE_DEF, oaf_pkg::MODE_INC: begin
						mem_req.rd   = 1'b1;
						mem_req.addr = r_val;
						state_d      = oaf_pkg::ST_VAL;
					end
					oaf_pkg::MODE_INC_DEF: begin
						mem_req.rd   = 1'b1;
						mem_req.addr = r_val;
						state_d      = oaf_pkg::ST_PTR;
					end
					oaf_pkg::MODE_DEC: begin
						add_b        = (step_d == 3'd1) ? 16'hFFFF : 16'hFFFE;
						mem_req.rd   = 1'b1;
						mem_req.addr = add_sum;
						state_d      = oaf_pkg::ST_VAL;
					end
					oaf_pkg::MODE_DEC_DEF: begin
						add_b        = 16'hFFFE;
						mem_req.rd   = 1'b1;
						mem_req.addr = add_sum;
						state_d      = oaf_pkg::ST_PTR;
					end
					default: begin
						add_a        = pc_val;
						add_b        = {13'd0, pcs_q};
						mem_req.rd   = 1'b1;
						mem_req.addr = add_sum;
						state_d      = oaf_pkg::ST_IDX;
					end
				endcase
			end
			oaf_pkg::ST_IDX: begin
				add_a   = pc_val;
				add_b   = {13'd0, pcs_q};
				state_d = oaf_pkg::ST_IDXADD;
			end
			oaf_pkg::ST_IDXADD: begin
				add_a        = base_q;
				add_b        = x_q;
				mem_req.rd   = 1'b1;
				mem_req.addr = add_sum;
				state_d      = (cur_mode == oaf_pkg::MODE_IDX) ? oaf_pkg::ST_VAL
					: oaf_pkg::ST_PTR;
			end
			oaf_pkg::ST_PTR: begin
				mem_req.rd   = 1'b1;
				mem_req.addr = rd_data;
				state_d      = oaf_pkg::ST_VAL;
			end
			oaf_pkg::ST_VAL: opnd_done = 1'b1;
			oaf_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = oaf_pkg::ST_IDLE;
				end
			end
			default: state_d = oaf_pkg::ST_IDLE;
		endcase
		if (opnd_done) state_d = op_q ? oaf_pkg::ST_DONE : oaf_pkg::ST_OPND;
	end

	// request latch
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q      <= oaf_pkg::req_t'(req_type);
			src_mode_q <= src_mode;
			src_reg_q  <= src_reg;
			dst_mode_q <= dst_mode;
			dst_reg_q  <= dst_reg;
			byte_q     <= byte_op;
			target_q   <= write_target;
			data_q     <= write_data;
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= 16'h0000;
		end else if (reg_we) begin
			regs_q[target_q[2:0]] <= data_q;
		end
	end

	// operand select and index byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= 1'b0;
			pcs_q <= 3'd0;
		end else begin
			if (state_q == oaf_pkg::ST_START) begin
				op_q  <= 1'b0;
				pcs_q <= 3'd0;
			end else begin
				if (opnd_done && !op_q) op_q <= 1'b1;
				if (state_q == oaf_pkg::ST_OPND && cur_mode[2:1] == 2'b11) begin
					pcs_q <= pcs_q + 3'd2;
				end
			end
		end
	end

	// address datapath
	always_ff @(posedge clk) begin
		if (mem_req.rd) addr_q <= mem_req.addr;
		if (state_q == oaf_pkg::ST_IDX) begin
			base_q <= (cur_reg == oaf_pkg::PC_REG) ? add_sum : r_val;
			x_q    <= rd_data;
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (state_q == oaf_pkg::ST_START) begin
			res_src_value_q   <= 16'h0000;
			res_src_address_q <= 16'h0000;
			res_src_step_q    <= 3'd0;
			res_dst_value_q   <= 16'h0000;
			res_dst_address_q <= 16'h0000;
			res_dst_step_q    <= 3'd0;
			res_pc_step_q     <= 3'd0;
			res_ack_q         <= start_ack;
		end else if (opnd_done) begin
			if (op_q) begin
				res_dst_value_q   <= opnd_val;
				res_dst_address_q <= opnd_addr;
				res_dst_step_q    <= opnd_step;
				res_pc_step_q     <= pcs_q;
			end else begin
				res_src_value_q   <= opnd_val;
				res_src_address_q <= opnd_addr;
				res_src_step_q    <= opnd_step;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			src_value_q   <= res_src_value_q;
			src_address_q <= res_src_address_q;
			src_step_q    <= res_src_step_q;
			dst_value_q   <= res_dst_value_q;
			dst_address_q <= res_dst_address_q;
			dst_step_q    <= res_dst_step_q;
			pc_step_q     <= res_pc_step_q;
			write_ack_q   <= res_ack_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign src_value   = src_value_q;
	assign src_address = src_address_q;
	assign src_step    = src_step_q;
	assign dst_value   = dst_value_q;
	assign dst_address = dst_address_q;
	assign dst_step    = dst_step_q;
	assign pc_step     = pc_step_q;
	assign write_ack   = write_ack_q;

	// index byte count only takes whole index words
	assert property (@(posedge clk) disable iff (!arst_n)
		pcs_q == 3'd0 || pcs_q == 3'd2 || pcs_q == 3'd4)
		else $error("index byte count out of range");

	// an accepted request always starts the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == oaf_pkg::ST_START)
		else $error("accepted request did not start");

	// every memory read is consumed by the next state
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd |=> (state_q == oaf_pkg::ST_IDX || state_q == oaf_pkg::ST_PTR
			|| state_q == oaf_pkg::ST_VAL))
		else $error("memory read data dropped");

	// a write acknowledgement never carries fetch results
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && write_ack_q |-> pc_step_q == 3'd0 && src_address_q == 16'h0000
			&& dst_address_q == 16'h0000)
		else $error("write result carries fetch fields");

	// register and memory writes happen only at request start
	assert property (@(posedge clk) disable iff (!arst_n)
		(reg_we || mem_req.wr) |-> state_q == oaf_pkg::ST_START)
		else $error("state written outside request start");

endmodule

>>> design/oaf_mem.sv
module oaf_mem #(
	parameter int unsigned MEM_WORDS = oaf_pkg::MEM_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  oaf_pkg::mem_req_t  req,
	output logic [15:0]        rd_data
);

	localparam int unsigned AW        = $clog2(MEM_WORDS);
	localparam logic [15:0] MEM_LIMIT = 16'(MEM_WORDS);

	logic [15:0]   mem [MEM_WORDS];
	logic [15:0]   rdata_q;
	logic          oob_q;
	logic          oob;
	logic [AW-1:0] idx;

	assign oob = oaf_pkg::word_oob(req.addr, MEM_LIMIT);
	assign idx = req.addr[AW:1];

	// single port array, registered read
	always_ff @(posedge clk) begin
		if (req.wr && !oob) begin
			mem[idx] <= req.wdata;
		end
		if (req.rd && !oob) begin
			rdata_q <= mem[idx];
		end
	end

	// out of range reads return zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oob_q <= 1'b1;
		end else if (req.rd) begin
			oob_q <= oob;
		end
	end

	assign rd_data = oob_q ? 16'h0000 : rdata_q;

endmodule
